FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by marker_relocation_stream.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds, off while rst is high.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: src/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// Types, codes and helper functions for the marker relocation stream.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int unsigned WordW = 32;

  // Input actions
  localparam logic [1:0] ACT_WORD   = 2'd0;
  localparam logic [1:0] ACT_EOM    = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_START  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_ROM_BASE = 1'b0;
  localparam logic CFG_RAM_BASE = 1'b1;

  // Marker triple phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HEAD  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  // Job kinds
  localparam logic [1:0] JOB_ONE     = 2'd0;
  localparam logic [1:0] JOB_TWO     = 2'd1;
  localparam logic [1:0] JOB_TRAILER = 2'd2;

  localparam logic [WordW-1:0] MK_RAM_HEAD = 32'h353a_b756;
  localparam logic [WordW-1:0] MK_RAM_TAIL = 32'hacb8_562d;
  localparam logic [WordW-1:0] MK_ROM_HEAD = 32'h38ab_1ef0;
  localparam logic [WordW-1:0] MK_ROM_TAIL = 32'h6184_abe6;
  localparam logic [WordW-1:0] TRL_A       = 32'hf1f2_f3f4;
  localparam logic [WordW-1:0] TRL_B       = 32'he1e2_e3e4;
  localparam logic [WordW-1:0] TRL_C       = 32'hd1d2_d3d4;
  localparam logic [WordW-1:0] TRL_END     = 32'hfdea_3b59;

  typedef struct packed {
    logic [1:0]       action;
    logic [WordW-1:0] in_word;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] out_word;
    logic             last_of_run;
  } out_t;

  // One job carries every result word of one input transaction.
  typedef struct packed {
    logic [1:0]       kind;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } job_t;

  // Handshake from the expander back to the job queue.
  typedef struct packed {
    logic pop;
  } q_ctl_t;

  function automatic logic [2:0] job_len(input logic [1:0] kind);
    logic [2:0] len;
    case (kind)
      JOB_TWO:     len = 3'd2;
      JOB_TRAILER: len = 3'd6;
      default:     len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [WordW-1:0] job_word(input job_t job, input logic [2:0] idx);
    logic [WordW-1:0] w;
    if (job.kind == JOB_TRAILER) begin
      case (idx)
        3'd0:    w = TRL_A;
        3'd1:    w = TRL_B;
        3'd2:    w = TRL_C;
        3'd3:    w = job.a;
        3'd4:    w = job.b;
        default: w = TRL_END;
      endcase
    end else begin
      w = (idx == 3'd0) ? job.a : job.b;
    end
    return w;
  endfunction

endpackage

FILE: src/mrs_core.sv
// ----------------------------------------------------------------------------
// mrs_core
// Cursor, module and marker state; turns each producing transaction into a job.
// ----------------------------------------------------------------------------
module mrs_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    accept,
  input  mrs_pkg::in_t            item,
  output logic                    job_push,
  output mrs_pkg::job_t           job
);
  import mrs_pkg::*;

  logic [WordW-1:0] rom_base, ram_base;
  logic [WordW-1:0] rom_cursor, rom_cursor_next;
  logic [WordW-1:0] ram_cursor, ram_cursor_next;
  logic [1:0]       triple_phase, triple_phase_next;
  logic             marker_is_ram, marker_is_ram_next;
  logic [WordW-1:0] held_value, held_value_next;
  logic [WordW-1:0] module_stack, module_stack_next;
  logic [WordW-1:0] module_bytes, module_bytes_next;
  logic [WordW-1:0] tail;

  assign tail = marker_is_ram ? MK_RAM_TAIL : MK_ROM_TAIL;

  always_comb begin
    rom_cursor_next    = rom_cursor;
    ram_cursor_next    = ram_cursor;
    triple_phase_next  = triple_phase;
    marker_is_ram_next = marker_is_ram;
    held_value_next    = held_value;
    module_stack_next  = module_stack;
    module_bytes_next  = module_bytes;
    job_push           = 1'b0;
    job.kind           = JOB_ONE;
    job.a              = item.in_word;
    job.b              = item.in_word;
    if (accept) begin
      unique case (item.action)
        ACT_WORD: begin
          if (triple_phase == PH_HEAD) begin
            held_value_next   = item.in_word;
            triple_phase_next = PH_VALUE;
          end else if (triple_phase == PH_VALUE) begin
            job_push          = 1'b1;
            triple_phase_next = PH_IDLE;
            if (item.in_word == tail) begin
              if (marker_is_ram) begin
                if (module_bytes == '0) begin
                  module_stack_next = held_value;
                end
                job.a = held_value + ram_cursor;
              end else begin
                job.a = held_value + rom_cursor;
              end
              module_bytes_next = module_bytes + 32'd4;
            end else begin
              job.kind          = JOB_TWO;
              job.a             = held_value;
              module_bytes_next = module_bytes + 32'd8;
            end
          end else if (item.in_word == MK_RAM_HEAD) begin
            marker_is_ram_next = 1'b1;
            triple_phase_next  = PH_HEAD;
          end else if (item.in_word == MK_ROM_HEAD) begin
            marker_is_ram_next = 1'b0;
            triple_phase_next  = PH_HEAD;
          end else begin
            job_push          = 1'b1;
            module_bytes_next = module_bytes + 32'd4;
          end
        end
        ACT_EOM: begin
          rom_cursor_next    = rom_cursor + module_bytes;
          ram_cursor_next    = ram_cursor + module_stack;
          triple_phase_next  = PH_IDLE;
          marker_is_ram_next = 1'b0;
          held_value_next    = '0;
          module_stack_next  = '0;
          module_bytes_next  = '0;
        end
        ACT_FINISH: begin
          job_push = 1'b1;
          job.kind = JOB_TRAILER;
          job.a    = rom_cursor;
          job.b    = ram_cursor;
        end
        ACT_START: begin
          rom_cursor_next    = rom_base;
          ram_cursor_next    = ram_base;
          triple_phase_next  = PH_IDLE;
          marker_is_ram_next = 1'b0;
          held_value_next    = '0;
          module_stack_next  = '0;
          module_bytes_next  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_base      <= '0;
      ram_base      <= '0;
      rom_cursor    <= '0;
      ram_cursor    <= '0;
      triple_phase  <= PH_IDLE;
      marker_is_ram <= 1'b0;
      held_value    <= '0;
      module_stack  <= '0;
      module_bytes  <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_ROM_BASE) begin
        rom_base <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_RAM_BASE) begin
        ram_base <= cfg_data;
      end
      rom_cursor    <= rom_cursor_next;
      ram_cursor    <= ram_cursor_next;
      triple_phase  <= triple_phase_next;
      marker_is_ram <= marker_is_ram_next;
      held_value    <= held_value_next;
      module_stack  <= module_stack_next;
      module_bytes  <= module_bytes_next;
    end
  end

endmodule

FILE: src/mrs_job_queue.sv
// ----------------------------------------------------------------------------
// mrs_job_queue
// Two-entry queue of pending jobs between the core and the expander.
// ----------------------------------------------------------------------------
module mrs_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrs_pkg::job_t  push_job,
  input  mrs_pkg::q_ctl_t ctl_in,
  output logic           head_valid,
  output mrs_pkg::job_t  head_job,
  output logic           full,
  output logic [1:0]     count
);
  import mrs_pkg::*;

  job_t entries [2];
  logic wr_ptr, rd_ptr;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (ctl_in.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, ctl_in.pop};
    end
  end

endmodule

FILE: src/mrs_expand.sv
// ----------------------------------------------------------------------------
// mrs_expand
// Walk the head job word by word into the output register.
// ----------------------------------------------------------------------------
module mrs_expand (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  mrs_pkg::job_t   head_job,
  output mrs_pkg::q_ctl_t ctl,
  output logic            out_valid,
  input  logic            out_stall,
  output mrs_pkg::out_t   out_data
);
  import mrs_pkg::*;

  logic [2:0] idx;
  logic       advance;
  logic       last;

  assign advance = !out_valid || !out_stall;
  assign last    = (idx == job_len(head_job.kind) - 3'd1);
  assign ctl.pop = head_valid && advance && last;

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      out_data.out_word    <= job_word(head_job, idx);
      out_data.last_of_run <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= last ? 3'd0 : idx + 3'd1;
      end
    end
  end

endmodule

FILE: src/marker_relocation_stream.sv
// ----------------------------------------------------------------------------
// marker_relocation_stream
// Relocate marked RAM/ROM fields in a stream of 32-bit module image words.
// ----------------------------------------------------------------------------
// One input transaction is taken per clock. Its whole effect on the cursors
// and on the marker state is worked out in the cycle it is accepted, and the
// words it produces are stored as one job in a two-entry job queue. The
// expander drains that queue one output word per clock while out_stall is
// low, through the output register. A job holds one word, two for a failed
// marker triple and six for a finish trailer. The input stalls only while
// both queue entries are occupied. A job passes the queue entry and then the
// output register before its first word appears. Write rom_base and ram_base
// while the block is idle; a start action loads them into the cursors.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module marker_relocation_stream (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrs_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mrs_pkg::out_t       out_data
);
  import mrs_pkg::*;

  logic   accept;
  logic   finish_accept;
  logic   job_push;
  job_t   job;
  logic   head_valid;
  job_t   head_job;
  logic   q_full;
  logic [1:0] q_count;
  q_ctl_t q_ctl;

  // Hold the input off while the job queue has no free entry.
  assign in_stall      = q_full;
  assign accept        = in_valid && !in_stall;
  assign finish_accept = accept && (in_data.action == ACT_FINISH);

  // Update cursors and marker state, emit one job per producing transaction.
  mrs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_data),
    .job_push  (job_push),
    .job       (job)
  );

  mrs_job_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (job),
    .ctl_in     (q_ctl),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (q_full),
    .count      (q_count)
  );

  // Advance through the head job one word per output transaction.
  mrs_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .ctl        (q_ctl),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // A job is never pushed into a full queue.
  `ASSERT_NEVER(a_no_overflow, job_push && q_full, "job pushed into full queue")
  // The expander pops only a queue that holds a job.
  `ASSERT_NEVER(a_no_underflow, q_ctl.pop && (q_count == 2'd0), "pop from empty queue")
  // A finish transaction always leaves a job queued behind it.
  `ASSERT_CLK(a_finish_queued, finish_accept |=> q_count != 2'd0, "finish job lost")

endmodule
